// ===== hdl/rppdr_pkg.sv =====
// Shared types and constants for the rotated pixel plot / dirty box engine.
// No dependencies; every other file imports this package.
package rppdr_pkg;

    // Panel geometry
    localparam int PANEL_WIDTH  = 480;
    localparam int PANEL_HEIGHT = 480;
    localparam int PIXELS       = PANEL_WIDTH * PANEL_HEIGHT;

    // Derived widths
    localparam int ADDR_W  = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int XW      = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
    localparam int YW      = (PANEL_HEIGHT > 1) ? $clog2(PANEL_HEIGHT) : 1;
    localparam int BOX_MAX = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
    localparam int BOX_W   = $clog2(BOX_MAX + 1);
    localparam int CALC_W  = 14;            // signed room for 12-bit coords and panel sizes

    // Fixed field widths
    localparam int CMD_W   = 2;
    localparam int COORD_W = 12;
    localparam int CH_W    = 8;
    localparam int EDGE_W  = 9;
    localparam int COL_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PLOT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FILL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TAKE = 2'd2;

    // Rotation codes
    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_X_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_Y_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_X_MAX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_Y_MAX  = 3'd5;

    localparam logic [EDGE_W-1:0] CLIP_MAX_RESET = 9'd480;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [CH_W-1:0]           red;
        logic [CH_W-1:0]           green;
        logic [CH_W-1:0]           blue;
    } req_t;

    typedef struct packed {
        logic              pixel_changed;
        logic              box_empty;
        logic [EDGE_W-1:0] box_left;
        logic [EDGE_W-1:0] box_top;
        logic [EDGE_W-1:0] box_right;
        logic [EDGE_W-1:0] box_bottom;
    } rsp_t;

    // Controller -> datapath
    typedef struct packed {
        logic ld_item;      // latch accepted item, clear result
        logic ld_pos;       // clip and rotate
        logic ld_addr;      // form store address
        logic rd_en;        // read stored pixel
        logic wr_plot;      // write pixel, grow box
        logic fill_step;    // write one fill pixel
        logic fill_box;     // mark whole frame dirty
        logic take_box;     // report box and reset it
        logic ld_out;       // move result into output register
    } ctrl_t;

    // Datapath -> controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             pos_ok;
        logic             differ;
        logic             fill_last;
        logic             fill_allowed;
    } stat_t;

    function automatic logic [COL_W-1:0] pack565(input logic [CH_W-1:0] r,
                                                 input logic [CH_W-1:0] g,
                                                 input logic [CH_W-1:0] b);
        pack565 = {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

// ===== hdl/rotated_pixel_plot_dirty_rect_top.sv =====
// Frame-store engine for a 480x480 RGB565 panel: plot, fill and take-dirty items
// with rotation, clip window and dirty bounding box. Depends on rppdr_pkg,
// rppdr_ctrl and rppdr_dp.
//
// One item at a time. A plot goes accept, decode (clip and rotate), address
// (y*width + x), store read, compare/write and result; the next item is taken
// only after the result step. Plots that are clipped or land off the panel finish
// after the address step. Take-dirty and unknown commands go from decode straight
// to the result step. A fill writes one pixel per cycle through the store's write
// port, for every pixel of the panel, and is skipped while clipping is enabled.
// The result sits in an output register, so the next item is accepted while it
// waits to be taken. Exactly one result item per input item. The store is not
// cleared after reset; plotting onto a pixel that was never filled or plotted
// gives an undefined pixel_changed. The configuration channel is always ready and
// should only be written while the engine is idle.
module rotated_pixel_plot_dirty_rect_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rppdr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rppdr_pkg::CFG_DATA_W-1:0] cfg_data,
    // items in
    input  logic                             req_valid,
    output logic                             req_ready,
    input  rppdr_pkg::req_t                  req,
    // results out
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output rppdr_pkg::rsp_t                  rsp
);
    import rppdr_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    // Register writes take effect at once
    assign cfg_ready = 1'b1;

    rppdr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    rppdr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .ctrl      (ctrl),
        .stat      (stat)
    );

endmodule

// ===== hdl/rppdr_ctrl.sv =====
// Sequencing state machine for the pixel plot engine.
// Depends on rppdr_pkg; drives rppdr_dp through ctrl_t.
module rppdr_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    input  rppdr_pkg::stat_t stat,
    output rppdr_pkg::ctrl_t ctrl
);
    import rppdr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ADDR,
        S_READ,
        S_CMP,
        S_FILL,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        ctrl           = '0;
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctrl.ld_item = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ctrl.ld_pos = 1'b1;
                case (stat.cmd)
                    CMD_PLOT: state_next = S_ADDR;
                    CMD_FILL: state_next = stat.fill_allowed ? S_FILL : S_DONE;
                    CMD_TAKE:
                    begin
                        ctrl.take_box = 1'b1;
                        state_next    = S_DONE;
                    end
                    default:  state_next = S_DONE;
                endcase
            end
            S_ADDR:
            begin
                ctrl.ld_addr = 1'b1;
                state_next   = stat.pos_ok ? S_READ : S_DONE;
            end
            S_READ:
            begin
                ctrl.rd_en = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                ctrl.wr_plot = stat.differ;
                state_next   = S_DONE;
            end
            S_FILL:
            begin
                ctrl.fill_step = 1'b1;
                if (stat.fill_last)
                begin
                    ctrl.fill_box = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    ctrl.ld_out    = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ===== hdl/rppdr_dp.sv =====
// Datapath: configuration registers, clip and rotate, frame store, dirty box.
// Depends on rppdr_pkg; steered by rppdr_ctrl.
module rppdr_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [rppdr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rppdr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  rppdr_pkg::req_t                     req,
    output rppdr_pkg::rsp_t                     rsp,
    input  rppdr_pkg::ctrl_t                    ctrl,
    output rppdr_pkg::stat_t                    stat
);
    import rppdr_pkg::*;

    localparam logic signed [CALC_W-1:0] PW_S  = CALC_W'(PANEL_WIDTH);
    localparam logic signed [CALC_W-1:0] PH_S  = CALC_W'(PANEL_HEIGHT);
    localparam logic signed [CALC_W-1:0] PW_M1 = CALC_W'(PANEL_WIDTH - 1);
    localparam logic signed [CALC_W-1:0] PH_M1 = CALC_W'(PANEL_HEIGHT - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(PIXELS - 1);

    // Configuration
    logic [1:0]        rot_reg;
    logic              clip_en_reg;
    logic [EDGE_W-1:0] cx_min_reg, cy_min_reg, cx_max_reg, cy_max_reg;

    // Latched item
    logic [CMD_W-1:0]          cmd_reg;
    logic signed [COORD_W-1:0] x_reg, y_reg;
    logic [COL_W-1:0]          colour_reg;

    // Plot pipeline
    logic [XW-1:0]     px_reg;
    logic [YW-1:0]     py_reg;
    logic              pos_ok_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [COL_W-1:0]  rd_q_reg;
    logic [ADDR_W-1:0] fill_cnt_reg;

    // Dirty box
    logic [BOX_W-1:0] left_reg, top_reg, right_reg, bottom_reg;

    // Result and output register
    rsp_t res_reg;
    rsp_t rsp_reg;

    // Frame store
    logic [COL_W-1:0] mem [PIXELS];

    // Clip and rotate
    logic signed [CALC_W-1:0] xs, ys, pxs, pys;
    logic signed [CALC_W-1:0] cxmin_s, cymin_s, cxmax_s, cymax_s;
    logic                     clip_out, in_panel;
    logic [ADDR_W-1:0]        addr_next;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [BOX_W-1:0]         px_b, py_b;

    assign xs      = CALC_W'(x_reg);
    assign ys      = CALC_W'(y_reg);
    assign cxmin_s = $signed({{(CALC_W-EDGE_W){1'b0}}, cx_min_reg});
    assign cymin_s = $signed({{(CALC_W-EDGE_W){1'b0}}, cy_min_reg});
    assign cxmax_s = $signed({{(CALC_W-EDGE_W){1'b0}}, cx_max_reg});
    assign cymax_s = $signed({{(CALC_W-EDGE_W){1'b0}}, cy_max_reg});

    assign clip_out = clip_en_reg &&
                      (xs < cxmin_s || xs >= cxmax_s || ys < cymin_s || ys >= cymax_s);

    always_comb
    begin
        case (rot_reg)
            ROT_90:
            begin
                pxs = PW_M1 - ys;
                pys = xs;
            end
            ROT_180:
            begin
                pxs = PW_M1 - xs;
                pys = PH_M1 - ys;
            end
            ROT_270:
            begin
                pxs = ys;
                pys = PH_M1 - xs;
            end
            default:
            begin
                pxs = xs;
                pys = ys;
            end
        endcase
    end

    assign in_panel  = !pxs[CALC_W-1] && (pxs < PW_S) && !pys[CALC_W-1] && (pys < PH_S);
    assign addr_next = ADDR_W'(ADDR_W'(py_reg) * ADDR_W'(PANEL_WIDTH) + ADDR_W'(px_reg));

    assign px_b = BOX_W'(px_reg);
    assign py_b = BOX_W'(py_reg);

    assign wr_en   = ctrl.wr_plot || ctrl.fill_step;
    assign wr_addr = ctrl.fill_step ? fill_cnt_reg : addr_reg;

    assign stat.cmd          = cmd_reg;
    assign stat.pos_ok       = pos_ok_reg;
    assign stat.differ       = (rd_q_reg != colour_reg);
    assign stat.fill_last    = (fill_cnt_reg == LAST_ADDR);
    assign stat.fill_allowed = !clip_en_reg;

    assign rsp = rsp_reg;

    // Store: one write port, one registered read port, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= colour_reg;
        end
        if (ctrl.rd_en)
        begin
            rd_q_reg <= mem[addr_reg];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.ld_item)
        begin
            cmd_reg    <= req.cmd;
            x_reg      <= req.pos_x;
            y_reg      <= req.pos_y;
            colour_reg <= pack565(req.red, req.green, req.blue);
        end
        if (ctrl.ld_pos)
        begin
            px_reg     <= pxs[XW-1:0];
            py_reg     <= pys[YW-1:0];
            pos_ok_reg <= !clip_out && in_panel;
        end
        if (ctrl.ld_addr)
        begin
            addr_reg <= addr_next;
        end
        if (ctrl.ld_item)
        begin
            fill_cnt_reg <= '0;
        end
        else if (ctrl.fill_step)
        begin
            fill_cnt_reg <= fill_cnt_reg + 1'b1;
        end
        if (ctrl.ld_out)
        begin
            rsp_reg <= res_reg;
        end
    end

    // Result assembly
    always_ff @(posedge clk)
    begin
        if (ctrl.ld_item)
        begin
            res_reg <= '0;
        end
        else if (ctrl.wr_plot)
        begin
            res_reg.pixel_changed <= 1'b1;
        end
        else if (ctrl.take_box)
        begin
            res_reg.box_empty  <= (left_reg > right_reg) || (top_reg > bottom_reg);
            res_reg.box_left   <= EDGE_W'(left_reg);
            res_reg.box_top    <= EDGE_W'(top_reg);
            res_reg.box_right  <= EDGE_W'(right_reg);
            res_reg.box_bottom <= EDGE_W'(bottom_reg);
        end
    end

    // Configuration and dirty box
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg     <= ROT_0;
            clip_en_reg <= 1'b0;
            cx_min_reg  <= '0;
            cy_min_reg  <= '0;
            cx_max_reg  <= CLIP_MAX_RESET;
            cy_max_reg  <= CLIP_MAX_RESET;
            left_reg    <= BOX_W'(PANEL_WIDTH);
            top_reg     <= BOX_W'(PANEL_HEIGHT);
            right_reg   <= '0;
            bottom_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_ROTATION:    rot_reg     <= cfg_data[1:0];
                    REG_CLIP_ENABLE: clip_en_reg <= cfg_data[0];
                    REG_CLIP_X_MIN:  cx_min_reg  <= cfg_data;
                    REG_CLIP_Y_MIN:  cy_min_reg  <= cfg_data;
                    REG_CLIP_X_MAX:  cx_max_reg  <= cfg_data;
                    REG_CLIP_Y_MAX:  cy_max_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (ctrl.wr_plot)
            begin
                if (px_b < left_reg)   left_reg   <= px_b;
                if (py_b < top_reg)    top_reg    <= py_b;
                if (px_b > right_reg)  right_reg  <= px_b;
                if (py_b > bottom_reg) bottom_reg <= py_b;
            end
            else if (ctrl.fill_box)
            begin
                left_reg   <= '0;
                top_reg    <= '0;
                right_reg  <= BOX_W'(PANEL_WIDTH - 1);
                bottom_reg <= BOX_W'(PANEL_HEIGHT - 1);
            end
            else if (ctrl.take_box)
            begin
                left_reg   <= BOX_W'(PANEL_WIDTH);
                top_reg    <= BOX_W'(PANEL_HEIGHT);
                right_reg  <= '0;
                bottom_reg <= '0;
            end
        end
    end

endmodule

// ===== hdl/rppdr_checker.sv =====
// Port-level checks for the pixel plot engine, bound to the top level.
// Depends on rppdr_pkg and rotated_pixel_plot_dirty_rect_top.
module rppdr_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_ready,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input rppdr_pkg::rsp_t rsp
);
    import rppdr_pkg::*;

    // Stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result changed while stalled");

    // Only one item in flight: no acceptance straight after one
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("item accepted while busy");

    // A plot result carries no box report
    a_plot_no_box: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.pixel_changed |-> !rsp.box_empty && rsp.box_left == '0
            && rsp.box_top == '0 && rsp.box_right == '0 && rsp.box_bottom == '0)
        else $error("plot result with box fields");

    // A non-empty box is ordered
    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.box_empty |-> rsp.box_left <= rsp.box_right
            && rsp.box_top <= rsp.box_bottom)
        else $error("non-empty box out of order");

endmodule

bind rotated_pixel_plot_dirty_rect_top rppdr_checker u_rppdr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
